/* hdl/urx_pkg.sv */
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types and constants for the 8N1 serial receiver.
// ----------------------------------------------------------------------------
package urx_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned REG_W  = 2;

  // register indexes on the configuration port
  localparam logic [REG_W-1:0] REG_START_DELAY = 2'd0;
  localparam logic [REG_W-1:0] REG_BIT_PERIOD  = 2'd1;
  localparam logic [REG_W-1:0] REG_STOP_DELAY  = 2'd2;

  localparam logic [TICK_W-1:0] START_DELAY_RST = 16'd8;
  localparam logic [TICK_W-1:0] BIT_PERIOD_RST  = 16'd16;
  localparam logic [TICK_W-1:0] STOP_DELAY_RST  = 16'd16;

  typedef struct packed {
    logic [TICK_W-1:0] start_delay;
    logic [TICK_W-1:0] bit_period;
    logic [TICK_W-1:0] stop_delay;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } result_t;

endpackage

/* hdl/uart_receiver_8n1.sv */
// ----------------------------------------------------------------------------
// uart_receiver_8n1
// Serial receiver taking one line sample per word and returning data bytes.
// ----------------------------------------------------------------------------
// Input channel: each accepted word (in_valid_i high, in_stall_o low) is one
// sample tick carrying rx_level_i. A low level while idle starts a frame; the
// bits are then sampled on tick counts set by the three timing registers,
// least significant bit first. Start and stop bits are not checked.
// Output channel: one data_byte_o word per frame, presented on out_valid_o
// the cycle after the tick that samples the last data bit if the output
// register is free, else via the skid stage; held while out_stall_i is high.
// Throughput is one tick per cycle while in_stall_o is low; the frame sequencer
// updates its state in the same cycle a tick is accepted, and the result lands
// in the output register. A skid stage absorbs one more byte while the output
// is stalled; in_stall_o rises only when that stage is occupied.
// Configuration: write cfg_data_i to register cfg_index_i when cfg_we_i is
// high (0 start delay, 1 bit period, 2 stop delay); other indexes are dropped.
// Reset returns the sequencer to idle, empties the output stages and loads
// the timing registers with 8, 16 and 16 ticks.
module uart_receiver_8n1 #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       rx_level_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [urx_pkg::BYTE_W-1:0] data_byte_o,
  input  logic                       cfg_we_i,
  input  logic [urx_pkg::REG_W-1:0]  cfg_index_i,
  input  logic [urx_pkg::TICK_W-1:0] cfg_data_i
);

  urx_pkg::cfg_t    cfg;
  urx_pkg::result_t res;
  logic             tick;
  logic             full;

  assign in_stall_o = full;
  assign tick       = in_valid_i && !full;

  urx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  urx_frame_fsm #(
    .DATA_BITS (DATA_BITS)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .level_i (rx_level_i),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  urx_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (data_byte_o)
  );

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with output register empty");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("skid stage filled without a stalled output");

  a_result_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (in_valid_i && !in_stall_o))
    else $error("byte produced without an accepted tick");

endmodule

/* hdl/urx_cfg_regs.sv */
// ----------------------------------------------------------------------------
// urx_cfg_regs
// Timing registers: start delay, bit period and stop delay in ticks.
// ----------------------------------------------------------------------------
module urx_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [urx_pkg::REG_W-1:0]  cfg_index_i,
  input  logic [urx_pkg::TICK_W-1:0] cfg_data_i,
  output urx_pkg::cfg_t              cfg_o
);

  urx_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delay <= urx_pkg::START_DELAY_RST;
      cfg_q.bit_period  <= urx_pkg::BIT_PERIOD_RST;
      cfg_q.stop_delay  <= urx_pkg::STOP_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        urx_pkg::REG_START_DELAY: cfg_q.start_delay <= cfg_data_i;
        urx_pkg::REG_BIT_PERIOD:  cfg_q.bit_period  <= cfg_data_i;
        urx_pkg::REG_STOP_DELAY:  cfg_q.stop_delay  <= cfg_data_i;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/urx_frame_fsm.sv */
// ----------------------------------------------------------------------------
// urx_frame_fsm
// Frame sequencer: start detect, tick counting and data bit assembly.
// ----------------------------------------------------------------------------
module urx_frame_fsm #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic             level_i,
  input  urx_pkg::cfg_t    cfg_i,
  output urx_pkg::result_t res_o
);

  localparam logic [urx_pkg::IDX_W-1:0] LastIdx = urx_pkg::IDX_W'(DATA_BITS - 1);
  localparam logic [urx_pkg::BYTE_W-1:0] DataMask =
    urx_pkg::BYTE_W'((1 << DATA_BITS) - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_STOP
  } phase_e;

  phase_e                        phase_q;
  logic [urx_pkg::TICK_W-1:0]    tick_q;
  logic [urx_pkg::IDX_W-1:0]     idx_q;
  logic [urx_pkg::BYTE_W-1:0]    shift_q;

  logic [urx_pkg::TICK_W-1:0]    tick_dec;
  logic [urx_pkg::TICK_W-1:0]    period_load;
  logic [urx_pkg::BYTE_W-1:0]    shift_d;
  logic                          sample;

  assign tick_dec    = tick_q - urx_pkg::TICK_W'(1);
  assign period_load = (cfg_i.bit_period == '0) ? urx_pkg::TICK_W'(1) : cfg_i.bit_period;
  assign sample      = tick_i && (phase_q == PH_DATA) && (tick_dec == '0);

  always_comb begin
    shift_d        = shift_q;
    shift_d[idx_q] = shift_q[idx_q] | level_i;
  end

  assign res_o.valid = sample && (idx_q >= LastIdx);
  assign res_o.data  = shift_d & DataMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      idx_q   <= '0;
      shift_q <= '0;
    end else if (tick_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (!level_i) begin
            idx_q   <= '0;
            shift_q <= '0;
            if (cfg_i.start_delay == '0) begin
              phase_q <= PH_DATA;
              tick_q  <= period_load;
            end else begin
              phase_q <= PH_START;
              tick_q  <= cfg_i.start_delay;
            end
          end
        end
        PH_START: begin
          if (tick_dec == '0) begin
            phase_q <= PH_DATA;
            tick_q  <= period_load;
          end else begin
            tick_q <= tick_dec;
          end
        end
        PH_DATA: begin
          if (tick_dec != '0) begin
            tick_q <= tick_dec;
          end else begin
            shift_q <= shift_d;
            if (idx_q >= LastIdx) begin
              idx_q <= '0;
              if (cfg_i.stop_delay == '0) begin
                phase_q <= PH_IDLE;
                tick_q  <= '0;
              end else begin
                phase_q <= PH_STOP;
                tick_q  <= cfg_i.stop_delay;
              end
            end else begin
              idx_q  <= idx_q + urx_pkg::IDX_W'(1);
              tick_q <= period_load;
            end
          end
        end
        PH_STOP: begin
          tick_q <= tick_dec;
          if (tick_dec == '0) begin
            phase_q <= PH_IDLE;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

endmodule

/* hdl/urx_out_buf.sv */
// ----------------------------------------------------------------------------
// urx_out_buf
// Output register with a skid stage so ticks keep flowing under stall until it fills.
// ----------------------------------------------------------------------------
module urx_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  urx_pkg::result_t           res_i,
  output logic                       full_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [urx_pkg::BYTE_W-1:0] data_o
);

  logic                       out_valid_q;
  logic [urx_pkg::BYTE_W-1:0] out_data_q;
  logic                       skid_valid_q;
  logic [urx_pkg::BYTE_W-1:0] skid_data_q;
  logic                       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // drain the skid word first; a new word only arrives while it is empty
      out_valid_q  <= skid_valid_q || res_i.valid;
      skid_valid_q <= 1'b0;
    end else if (res_i.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : res_i.data;
    end
    if (!out_free && res_i.valid) begin
      skid_data_q <= res_i.data;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Serial receiver check: line-sample words in, data bytes out.
// A scoreboard class tracks the frame sequencer tick by tick and queues the
// bytes it should emit. Directed frames cover long waits and zero delays,
// then random timing settings carry clean, glitchy and cut frames plus line
// noise, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DATA_BITS = 8;
  localparam logic [urx_pkg::IDX_W-1:0] LAST_BIT = urx_pkg::IDX_W'(DATA_BITS - 1);
  localparam logic [urx_pkg::REG_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_TICKS = 500;
  localparam int RANDOM_BYTES = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {LINE_IDLE, LINE_START, LINE_DATA, LINE_STOP} line_phase_e;

  class rx_byte_scoreboard;
    logic [urx_pkg::TICK_W-1:0] start_delay;
    logic [urx_pkg::TICK_W-1:0] bit_period;
    logic [urx_pkg::TICK_W-1:0] stop_delay;
    line_phase_e                phase;
    logic [urx_pkg::TICK_W-1:0] tick_count;
    logic [urx_pkg::IDX_W-1:0]  bit_index;
    logic [urx_pkg::BYTE_W-1:0] shift_value;
    logic [urx_pkg::BYTE_W-1:0] expected_bytes[$];
    int                         bytes_predicted;
    int                         mismatches;

    function new();
      start_delay     = urx_pkg::START_DELAY_RST;
      bit_period      = urx_pkg::BIT_PERIOD_RST;
      stop_delay      = urx_pkg::STOP_DELAY_RST;
      phase           = LINE_IDLE;
      tick_count      = '0;
      bit_index       = '0;
      shift_value     = '0;
      bytes_predicted = 0;
      mismatches      = 0;
    endfunction

    function void write_reg(logic [urx_pkg::REG_W-1:0] idx,
                            logic [urx_pkg::TICK_W-1:0] val);
      case (idx)
        urx_pkg::REG_START_DELAY: start_delay = val;
        urx_pkg::REG_BIT_PERIOD:  bit_period  = val;
        urx_pkg::REG_STOP_DELAY:  stop_delay  = val;
        default: ;
      endcase
    endfunction

    // a zero period counts as one tick
    function logic [urx_pkg::TICK_W-1:0] period_ticks();
      return (bit_period == '0) ? urx_pkg::TICK_W'(1) : bit_period;
    endfunction

    function void note_tick(logic level);
      case (phase)
        LINE_IDLE: begin
          if (!level) begin
            bit_index   = '0;
            shift_value = '0;
            if (start_delay == '0) begin
              phase      = LINE_DATA;
              tick_count = period_ticks();
            end else begin
              phase      = LINE_START;
              tick_count = start_delay;
            end
          end
        end
        LINE_START: begin
          tick_count = tick_count - 1'b1;
          if (tick_count == '0) begin
            phase      = LINE_DATA;
            tick_count = period_ticks();
          end
        end
        LINE_DATA: begin
          tick_count = tick_count - 1'b1;
          if (tick_count == '0) begin
            shift_value = shift_value | (urx_pkg::BYTE_W'(level) << bit_index);
            if (bit_index >= LAST_BIT) begin
              expected_bytes.push_back(shift_value);
              bytes_predicted++;
              bit_index = '0;
              if (stop_delay == '0) begin
                phase      = LINE_IDLE;
                tick_count = '0;
              end else begin
                phase      = LINE_STOP;
                tick_count = stop_delay;
              end
            end else begin
              bit_index  = bit_index + 1'b1;
              tick_count = period_ticks();
            end
          end
        end
        default: begin
          tick_count = tick_count - 1'b1;
          if (tick_count == '0) phase = LINE_IDLE;
        end
      endcase
    endfunction

    function void check_byte(logic [urx_pkg::BYTE_W-1:0] got);
      logic [urx_pkg::BYTE_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] data_byte: got 0x%02h, expected nothing", $realtime, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] data_byte: got 0x%02h, expected 0x%02h", $realtime, got, want);
        end
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       rx_level_i;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [urx_pkg::BYTE_W-1:0] data_byte_o;
  logic                       cfg_we_i;
  logic [urx_pkg::REG_W-1:0]  cfg_index_i;
  logic [urx_pkg::TICK_W-1:0] cfg_data_i;

  rx_byte_scoreboard sb;
  bit tx_gaps_on   = 1'b1;
  bit rx_gaps_on   = 1'b1;
  bit hold_off_req = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int ticks_sent   = 0;

  uart_receiver_8n1 #(
    .DATA_BITS(DATA_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_level_i (rx_level_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_byte_o(data_byte_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: random stalls, or one long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_gaps_on && ($urandom_range(99) < 18);
    end
  end

  // check bytes and watch for a hung handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_byte(data_byte_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  task automatic send_tick(input logic level);
    if (tx_gaps_on && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_level_i <= level;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_tick(level);
    ticks_sent++;
  endtask

  // hold the line high until the sequencer is back in idle, then frame a byte
  task automatic send_frame(input logic [urx_pkg::BYTE_W-1:0] value, input bit truncate,
                            input bit noisy);
    int   st;
    int   per;
    int   last_o;
    logic level;
    while (sb.phase != LINE_IDLE) send_tick(1'b1);
    repeat ($urandom_range(0, 2)) send_tick(1'b1);
    st     = sb.start_delay;
    per    = sb.period_ticks();
    last_o = st + DATA_BITS * per;
    if (truncate) last_o = int'($urandom_range(0, last_o - 1));
    for (int o = 0; o <= last_o; o++) begin
      level = (o <= st) ? 1'b0 : value[(o - st - 1) / per];
      if (noisy && o != 0 && $urandom_range(99) < 6) level = ~level;
      send_tick(level);
    end
  endtask

  task automatic drain_bytes();
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [urx_pkg::REG_W-1:0] idx,
                           input logic [urx_pkg::TICK_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [urx_pkg::TICK_W-1:0] st,
                            input logic [urx_pkg::TICK_W-1:0] per,
                            input logic [urx_pkg::TICK_W-1:0] sp);
    drain_bytes();
    write_reg(urx_pkg::REG_START_DELAY, st);
    write_reg(urx_pkg::REG_BIT_PERIOD, per);
    write_reg(urx_pkg::REG_STOP_DELAY, sp);
  endtask

  initial begin
    int ticks_mark;
    int bytes_mark;
    int epoch;
    int n_events;
    int pick;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_level_i  = 1'b1;
    cfg_we_i    = 1'b0;
    cfg_index_i = urx_pkg::REG_START_DELAY;
    cfg_data_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing, all-zero and all-one bytes
    send_frame(8'h00, 1'b0, 1'b0);
    send_frame(8'hFF, 1'b0, 1'b0);

    // zero start, period and stop: back-to-back frames with the line low
    set_timing('0, '0, '0);
    send_frame(8'h55, 1'b0, 1'b0);
    send_frame(8'hAA, 1'b0, 1'b0);
    send_frame(8'h00, 1'b0, 1'b0);
    send_frame(8'h00, 1'b0, 1'b0);
    send_frame(8'h80, 1'b0, 1'b0);
    send_frame(8'h01, 1'b0, 1'b0);

    // out-of-range index must leave the timing alone
    drain_bytes();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_frame(8'h5A, 1'b0, 1'b0);

    // long start and stop waits, then a long bit period, no idling
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    set_timing(16'd100, 16'd1, 16'd100);
    send_frame(8'h3C, 1'b0, 1'b0);
    while (sb.phase != LINE_IDLE) send_tick(1'b1);
    set_timing('0, 16'd24, '0);
    send_frame(8'hC3, 1'b0, 1'b0);

    ticks_mark = ticks_sent;
    bytes_mark = sb.bytes_predicted;
    epoch      = 0;
    while (ticks_sent - ticks_mark < RANDOM_TICKS ||
           sb.bytes_predicted - bytes_mark < RANDOM_BYTES) begin
      if (epoch == 0) begin
        // fill the output stages behind a long receiver hold-off
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        set_timing('0, 16'd1, '0);
        hold_off_req = 1'b1;
        n_events = 14;
      end else begin
        tx_gaps_on = ($urandom_range(3) != 0);
        rx_gaps_on = ($urandom_range(3) != 0);
        if ($urandom_range(7) == 0)
          set_timing(urx_pkg::TICK_W'($urandom_range(0, 40)),
                     urx_pkg::TICK_W'($urandom_range(0, 12)),
                     urx_pkg::TICK_W'($urandom_range(0, 40)));
        else
          set_timing(urx_pkg::TICK_W'($urandom_range(0, 4)),
                     urx_pkg::TICK_W'($urandom_range(0, 3)),
                     urx_pkg::TICK_W'($urandom_range(0, 4)));
        if ($urandom_range(3) == 0) write_reg(REG_UNUSED, urx_pkg::TICK_W'($urandom));
        n_events = int'($urandom_range(4, 10));
      end
      for (int i = 0; i < n_events; i++) begin
        pick = int'($urandom_range(99));
        if (pick < 70) send_frame(urx_pkg::BYTE_W'($urandom), 1'b0, 1'b0);
        else if (pick < 80) send_frame(urx_pkg::BYTE_W'($urandom), 1'b0, 1'b1);
        else if (pick < 90) send_frame(urx_pkg::BYTE_W'($urandom), 1'b1, 1'b0);
        else repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(1)));
      end
      epoch++;
    end

    drain_bytes();
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/urx_pkg.sv
hdl/urx_cfg_regs.sv
hdl/urx_frame_fsm.sv
hdl/urx_out_buf.sv
hdl/uart_receiver_8n1.sv
tb/sv/tb_top.sv
